FILE: src/rpod_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpod_pkg
// Shared widths and the transaction record handed along the square root row.
// ---------------------------------------------------------------------------
package rpod_pkg;

    localparam int POS_W    = 24;
    localparam int SIZE_W   = 16;
    localparam int MARGIN_W = 16;
    localparam int GAP_W    = 26;
    localparam int G_W      = 26;
    localparam int RAD_W    = 54;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int TOUCH_TOP    = 0;
    localparam int TOUCH_BOTTOM = 1;
    localparam int TOUCH_LEFT   = 2;
    localparam int TOUCH_RIGHT  = 3;

    typedef struct packed {
        logic              valid;
        logic              ovl;
        logic [3:0]        touch;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } rpod_cell_t;

endpackage

FILE: src/rpod_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpod_front
// Edge, centre and gap pipeline: six stages from accepted rectangles to the
// squared gap and the contact flags.
// ---------------------------------------------------------------------------
module rpod_front
    import rpod_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [POS_W-1:0]    a_x,
    input  logic signed [POS_W-1:0]    a_z,
    input  logic [SIZE_W-1:0]          a_width,
    input  logic [SIZE_W-1:0]          a_length,
    input  logic                       a_centered,
    input  logic signed [POS_W-1:0]    b_x,
    input  logic signed [POS_W-1:0]    b_z,
    input  logic [SIZE_W-1:0]          b_width,
    input  logic [SIZE_W-1:0]          b_length,
    input  logic                       b_centered,
    input  logic [MARGIN_W-1:0]        margin,
    output rpod_cell_t                 cell_out
);

    logic [5:0] v_reg;

    // stage 1
    logic signed [24:0] al_reg, at_reg, bl_reg, bt_reg;
    logic signed [25:0] acx_reg, acz_reg, bcx_reg, bcz_reg;
    logic [SIZE_W-1:0]  aw_reg, alen_reg, bw_reg, blen_reg;
    logic [16:0]        hw_reg, hl_reg;
    // stage 2
    logic signed [24:0] al2_reg, at2_reg, bl2_reg, bt2_reg;
    logic signed [25:0] ar_reg, ab_reg, br_reg, bb_reg;
    logic signed [26:0] cdx_reg, cdz_reg;
    logic [16:0]        hw2_reg, hl2_reg;
    // stage 3
    logic [25:0]        dx_reg, dz_reg;
    logic signed [26:0] et_reg, eb_reg, el_reg, er_reg;
    logic [16:0]        hw3_reg, hl3_reg;
    // stage 4
    logic [G_W-1:0]     gx_reg, gz_reg;
    logic               ovl4_reg;
    logic [3:0]         touch4_reg;
    // stage 5
    logic [2*G_W-1:0]   sqx_reg, sqz_reg;
    logic               ovl5_reg;
    logic [3:0]         touch5_reg;
    // stage 6
    logic [RAD_W-1:0]   rad_reg;
    logic               ovl6_reg;
    logic [3:0]         touch6_reg;

    logic [SIZE_W-2:0] ahw, ahl, bhw, bhl;
    assign ahw = a_width[SIZE_W-1:1];
    assign ahl = a_length[SIZE_W-1:1];
    assign bhw = b_width[SIZE_W-1:1];
    assign bhl = b_length[SIZE_W-1:1];

    function automatic logic [26:0] abs27(input logic signed [26:0] v);
        abs27 = v[26] ? 27'(-v) : 27'(v);
    endfunction

    logic [26:0] dx_abs, dz_abs;
    logic [26:0] gx_diff, gz_diff;
    assign dx_abs  = abs27(cdx_reg);
    assign dz_abs  = abs27(cdz_reg);
    assign gx_diff = {1'b0, dx_reg} - {10'b0, hw3_reg};
    assign gz_diff = {1'b0, dz_reg} - {10'b0, hl3_reg};

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        // edges and centres
        al_reg   <= 25'(a_x) - (a_centered ? 25'(ahw) : 25'sd0);
        at_reg   <= 25'(a_z) - (a_centered ? 25'(ahl) : 25'sd0);
        bl_reg   <= 25'(b_x) - (b_centered ? 25'(bhw) : 25'sd0);
        bt_reg   <= 25'(b_z) - (b_centered ? 25'(bhl) : 25'sd0);
        acx_reg  <= 26'(a_x) + (a_centered ? 26'sd0 : 26'(ahw));
        acz_reg  <= 26'(a_z) + (a_centered ? 26'sd0 : 26'(ahl));
        bcx_reg  <= 26'(b_x) + (b_centered ? 26'sd0 : 26'(bhw));
        bcz_reg  <= 26'(b_z) + (b_centered ? 26'sd0 : 26'(bhl));
        aw_reg   <= a_width;
        alen_reg <= a_length;
        bw_reg   <= b_width;
        blen_reg <= b_length;
        hw_reg   <= 17'({1'b0, a_width} + {1'b0, b_width} >> 1);
        hl_reg   <= 17'({1'b0, a_length} + {1'b0, b_length} >> 1);

        // far edges and centre differences
        al2_reg <= al_reg;
        at2_reg <= at_reg;
        bl2_reg <= bl_reg;
        bt2_reg <= bt_reg;
        ar_reg  <= 26'(al_reg) + 26'($signed({1'b0, aw_reg}));
        ab_reg  <= 26'(at_reg) + 26'($signed({1'b0, alen_reg}));
        br_reg  <= 26'(bl_reg) + 26'($signed({1'b0, bw_reg}));
        bb_reg  <= 26'(bt_reg) + 26'($signed({1'b0, blen_reg}));
        cdx_reg <= 27'(acx_reg) - 27'(bcx_reg);
        cdz_reg <= 27'(acz_reg) - 27'(bcz_reg);
        hw2_reg <= hw_reg;
        hl2_reg <= hl_reg;

        // absolute centre gaps and edge differences
        dx_reg  <= dx_abs[25:0];
        dz_reg  <= dz_abs[25:0];
        et_reg  <= 27'(at2_reg) - 27'(bb_reg);
        eb_reg  <= 27'(bt2_reg) - 27'(ab_reg);
        el_reg  <= 27'(al2_reg) - 27'(br_reg);
        er_reg  <= 27'(bl2_reg) - 27'(ar_reg);
        hw3_reg <= hw2_reg;
        hl3_reg <= hl2_reg;

        // clip gaps, decide overlap and contact
        gx_reg   <= (dx_reg > 26'(hw3_reg)) ? gx_diff[G_W-1:0] : '0;
        gz_reg   <= (dz_reg > 26'(hl3_reg)) ? gz_diff[G_W-1:0] : '0;
        ovl4_reg <= (dx_reg <= 26'(hw3_reg)) && (dz_reg <= 26'(hl3_reg));
        touch4_reg[TOUCH_TOP]    <= abs27(et_reg) < 27'(margin);
        touch4_reg[TOUCH_BOTTOM] <= abs27(eb_reg) < 27'(margin);
        touch4_reg[TOUCH_LEFT]   <= abs27(el_reg) < 27'(margin);
        touch4_reg[TOUCH_RIGHT]  <= abs27(er_reg) < 27'(margin);

        // squares
        sqx_reg    <= gx_reg * gx_reg;
        sqz_reg    <= gz_reg * gz_reg;
        ovl5_reg   <= ovl4_reg;
        touch5_reg <= touch4_reg;

        // sum of squares
        rad_reg    <= RAD_W'(sqx_reg) + RAD_W'(sqz_reg);
        ovl6_reg   <= ovl5_reg;
        touch6_reg <= touch5_reg;
    end

    assign cell_out.valid = v_reg[5];
    assign cell_out.ovl   = ovl6_reg;
    assign cell_out.touch = touch6_reg;
    assign cell_out.rad   = rad_reg;
    assign cell_out.rem   = '0;
    assign cell_out.root  = '0;

endmodule

FILE: src/rpod_sqrt_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rpod_sqrt_cell
// One digit of a restoring square root: takes two radicand bits, settles one
// root bit and hands the transaction to the next cell.
// ---------------------------------------------------------------------------
module rpod_sqrt_cell
    import rpod_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rpod_cell_t cell_in,
    output rpod_cell_t cell_out
);

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             take;
    rpod_cell_t       data_next;
    rpod_cell_t       data_reg;
    logic             valid_reg;

    // try the next root bit
    always_comb
    begin
        rem_sh = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1:RAD_W-2]};
        trial  = {cell_in.root, 2'b01};
        take   = rem_sh >= trial;
        data_next       = cell_in;
        data_next.rad   = {cell_in.rad[RAD_W-3:0], 2'b00};
        data_next.rem   = take ? rem_sh - trial : rem_sh;
        data_next.root  = {cell_in.root[ROOT_W-2:0], take};
    end

    // hold valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cell_in.valid;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // hand the transaction on
    always_comb
    begin
        cell_out       = data_reg;
        cell_out.valid = valid_reg;
    end

endmodule

FILE: src/rect_pair_overlap_distance.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rect_pair_overlap_distance
// Overlap, floored edge gap and edge contact of two axis-aligned rectangles.
// ---------------------------------------------------------------------------
// Usage: busy is always low, so a new rectangle pair may be started on every
// clock cycle. Each transaction gives one result, shown for one cycle with
// done high, after edge, gap and squaring arithmetic in the front pipeline
// and then a row of 27 square root cells that settle one root bit each.
// Results leave in start order and cannot be held off. The collision margin
// register (reset 1) is written through cfg_valid/cfg_data; cfg_ready is
// always high. Write it only while no transaction is in flight.
module rect_pair_overlap_distance
    import rpod_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [POS_W-1:0] a_x,
    input  logic signed [POS_W-1:0] a_z,
    input  logic [SIZE_W-1:0]       a_width,
    input  logic [SIZE_W-1:0]       a_length,
    input  logic                    a_centered,
    input  logic signed [POS_W-1:0] b_x,
    input  logic signed [POS_W-1:0] b_z,
    input  logic [SIZE_W-1:0]       b_width,
    input  logic [SIZE_W-1:0]       b_length,
    input  logic                    b_centered,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [MARGIN_W-1:0]     cfg_data,
    output logic                    done,
    output logic                    overlap,
    output logic [GAP_W-1:0]        gap_distance,
    output logic                    touch_top,
    output logic                    touch_bottom,
    output logic                    touch_left,
    output logic                    touch_right
);

    logic [MARGIN_W-1:0] margin_reg;
    rpod_cell_t          chain [0:ROOT_W];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // hold the collision margin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= MARGIN_W'(1);
        end
        else if (cfg_valid)
        begin
            margin_reg <= cfg_data;
        end
    end

    rpod_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (start),
        .a_x        (a_x),
        .a_z        (a_z),
        .a_width    (a_width),
        .a_length   (a_length),
        .a_centered (a_centered),
        .b_x        (b_x),
        .b_z        (b_z),
        .b_width    (b_width),
        .b_length   (b_length),
        .b_centered (b_centered),
        .margin     (margin_reg),
        .cell_out   (chain[0])
    );

    // row of square root cells, one root bit each
    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        rpod_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // drive result ports from the last cell
    assign done         = chain[ROOT_W].valid;
    assign overlap      = chain[ROOT_W].ovl;
    assign gap_distance = chain[ROOT_W].root[GAP_W-1:0];
    assign touch_top    = chain[ROOT_W].touch[TOUCH_TOP];
    assign touch_bottom = chain[ROOT_W].touch[TOUCH_BOTTOM];
    assign touch_left   = chain[ROOT_W].touch[TOUCH_LEFT];
    assign touch_right  = chain[ROOT_W].touch[TOUCH_RIGHT];

endmodule

FILE: tb/sv/tb_rect_pair_overlap_distance.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_rect_pair_overlap_distance
// Drives rectangle pairs through the overlap and gap block and compares every
// result, field by field, with a behavioural predictor of overlap, floored
// edge gap and edge contact, across several collision margin settings.
// ---------------------------------------------------------------------------
module tb_rect_pair_overlap_distance
    import rpod_pkg::*;
();

    localparam int DRAIN_CYCLES = 50;

    typedef struct {
        logic signed [POS_W-1:0] ax, az, bx, bz;
        logic [SIZE_W-1:0]       aw, al, bw, bl;
        logic                    ac, bc;
    } pair_t;

    typedef struct {
        logic             ovl;
        logic [GAP_W-1:0] gap;
        logic [3:0]       touch; // top, bottom, left, right
    } contact_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [POS_W-1:0] a_x = '0, a_z = '0, b_x = '0, b_z = '0;
    logic [SIZE_W-1:0] a_width = '0, a_length = '0, b_width = '0, b_length = '0;
    logic a_centered = 1'b0, b_centered = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [MARGIN_W-1:0] cfg_data = '0;
    logic done, overlap, touch_top, touch_bottom, touch_left, touch_right;
    logic [GAP_W-1:0] gap_distance;

    logic [MARGIN_W-1:0] margin_model;
    contact_t expected_contacts[$];
    int errors = 0;

    always #6 clk = ~clk;

    rect_pair_overlap_distance dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .a_x(a_x), .a_z(a_z), .a_width(a_width), .a_length(a_length),
        .a_centered(a_centered), .b_x(b_x), .b_z(b_z), .b_width(b_width),
        .b_length(b_length), .b_centered(b_centered), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data), .done(done),
        .overlap(overlap), .gap_distance(gap_distance), .touch_top(touch_top),
        .touch_bottom(touch_bottom), .touch_left(touch_left),
        .touch_right(touch_right)
    );

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint abs_gap(longint p, longint q);
        return (p > q) ? p - q : q - p;
    endfunction

    // Work out overlap, gap and contacts for one pair at the current margin
    function automatic contact_t rect_contact(pair_t p, logic [MARGIN_W-1:0] m);
        contact_t c;
        longint aw, al, bw, bl, al_e, at_e, bl_e, bt_e, dx, dz, hw, hl;
        longint unsigned gx, gz;
        aw = longint'(p.aw); al = longint'(p.al);
        bw = longint'(p.bw); bl = longint'(p.bl);
        al_e = longint'(p.ax) - (p.ac ? aw / 2 : 0);
        at_e = longint'(p.az) - (p.ac ? al / 2 : 0);
        bl_e = longint'(p.bx) - (p.bc ? bw / 2 : 0);
        bt_e = longint'(p.bz) - (p.bc ? bl / 2 : 0);
        dx = abs_gap(al_e + aw / 2, bl_e + bw / 2);
        dz = abs_gap(at_e + al / 2, bt_e + bl / 2);
        hw = (aw + bw) / 2;
        hl = (al + bl) / 2;
        c.ovl = (dx <= hw) && (dz <= hl);
        gx = (dx > hw) ? dx - hw : 0;
        gz = (dz > hl) ? dz - hl : 0;
        c.gap = c.ovl ? '0 : GAP_W'(floor_root(gx * gx + gz * gz));
        c.touch[3] = abs_gap(at_e, bt_e + bl) < longint'(m);
        c.touch[2] = abs_gap(bt_e, at_e + al) < longint'(m);
        c.touch[1] = abs_gap(al_e, bl_e + bw) < longint'(m);
        c.touch[0] = abs_gap(bl_e, al_e + aw) < longint'(m);
        return c;
    endfunction

    // Compare each strobed result with the oldest expectation
    always @(posedge clk)
    begin
        contact_t e;
        if (done)
        begin
            if (expected_contacts.size() == 0)
            begin
                $display("%0t: unexpected result ovl=%0b gap=%0d", $time, overlap,
                         gap_distance);
                errors++;
            end
            else
            begin
                e = expected_contacts.pop_front();
                if (overlap !== e.ovl || gap_distance !== e.gap ||
                    {touch_top, touch_bottom, touch_left, touch_right} !== e.touch)
                begin
                    $display("%0t: expected ovl=%0b gap=%0d touch=%b, got ovl=%0b gap=%0d touch=%b",
                             $time, e.ovl, e.gap, e.touch, overlap, gap_distance,
                             {touch_top, touch_bottom, touch_left, touch_right});
                    errors++;
                end
            end
        end
    end

    // Write the margin register, blocking until the write is taken
    task automatic write_margin(input logic [MARGIN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        margin_model = v;
        cfg_valid <= 1'b0;
    endtask

    // Offer one pair and hold start until the block takes it
    task automatic send_pair(input pair_t p, input logic last);
        start <= 1'b1;
        a_x <= p.ax; a_z <= p.az; a_width <= p.aw; a_length <= p.al;
        a_centered <= p.ac;
        b_x <= p.bx; b_z <= p.bz; b_width <= p.bw; b_length <= p.bl;
        b_centered <= p.bc;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_contacts.push_back(rect_contact(p, margin_model));
        if (last) start <= 1'b0;
    endtask

    task automatic drain();
        while (expected_contacts.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pair_t random_pair(bit near);
        pair_t p;
        int unsigned span;
        span = near ? 40000 : 0;
        p.ac = 1'($urandom_range(0, 1));
        p.bc = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
        begin
            p.aw = SIZE_W'($urandom); p.al = SIZE_W'($urandom);
            p.bw = SIZE_W'($urandom); p.bl = SIZE_W'($urandom);
        end
        else
        begin
            p.aw = SIZE_W'($urandom_range(0, 300)); p.al = SIZE_W'($urandom_range(0, 300));
            p.bw = SIZE_W'($urandom_range(0, 300)); p.bl = SIZE_W'($urandom_range(0, 300));
        end
        p.ax = POS_W'($urandom); p.az = POS_W'($urandom);
        if (near)
        begin
            // Place the second rectangle close to the first to hit edges
            p.bx = POS_W'(p.ax + POS_W'(int'($urandom_range(0, 2 * span)) - int'(span)) /
                   ($urandom_range(0, 1) ? 1 : 100));
            p.bz = POS_W'(p.az + POS_W'(int'($urandom_range(0, 2 * span)) - int'(span)) /
                   ($urandom_range(0, 1) ? 1 : 100));
        end
        else
        begin
            p.bx = POS_W'($urandom); p.bz = POS_W'($urandom);
        end
        return p;
    endfunction

    // Directed rows: extremes, centre and corner forms, zero sizes
    typedef struct {
        pair_t    p;
        bit       known;
        contact_t want;
    } row_t;

    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [SIZE_W-1:0] SMAX = '1;

    row_t stimulus_rows[] = '{
        '{'{'0, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0}, 1, '{1'b1, '0, 4'b1111}},
        '{'{PMAX, PMAX, PMIN, PMIN, SMAX, SMAX, SMAX, SMAX, 1'b0, 1'b0}, 0, '{0, 0, 0}},
        '{'{PMIN, PMIN, PMAX, PMAX, SMAX, SMAX, SMAX, SMAX, 1'b1, 1'b1}, 0, '{0, 0, 0}},
        '{'{PMIN, PMAX, PMAX, PMIN, '0, '0, '0, '0, 1'b1, 1'b0}, 0, '{0, 0, 0}},
        '{'{24'sd0, 24'sd0, 24'sd10, 24'sd0, 16'd10, 16'd10, 16'd10, 16'd10, 1'b0, 1'b0},
          0, '{0, 0, 0}},
        '{'{24'sd0, 24'sd0, 24'sd11, 24'sd0, 16'd10, 16'd10, 16'd10, 16'd10, 1'b1, 1'b1},
          0, '{0, 0, 0}},
        '{'{24'sd0, 24'sd0, 24'sd30, 24'sd40, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0},
          0, '{0, 0, 0}},
        '{'{-24'sd5, 24'sd7, 24'sd5, -24'sd7, 16'd3, 16'd5, 16'd7, 16'd9, 1'b1, 1'b0},
          0, '{0, 0, 0}},
        '{'{24'sd100, 24'sd100, 24'sd100, 24'sd100, SMAX, 16'd1, 16'd1, SMAX, 1'b1, 1'b1},
          0, '{0, 0, 0}},
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd20, 16'd20, 16'd20, 16'd20, 16'd20, 1'b0, 1'b0},
          0, '{0, 0, 0}}
    };

    initial
    begin
        int n;
        margin_model = MARGIN_W'(1);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at the reset margin, then at zero margin
        foreach (stimulus_rows[i])
        begin
            send_pair(stimulus_rows[i].p, i == stimulus_rows.size() - 1);
            if (stimulus_rows[i].known)
                expected_contacts[$] = stimulus_rows[i].want;
        end
        drain();
        write_margin('0);
        foreach (stimulus_rows[i])
            send_pair(stimulus_rows[i].p, i == stimulus_rows.size() - 1);
        drain();

        // Random phases across several margins, the extremes among them
        for (int k = 0; k < 5; k++)
        begin
            write_margin(k == 0 ? 16'd1 : k == 1 ? 16'hFFFF : k == 2 ? 16'd0 :
                         k == 3 ? 16'd37 : MARGIN_W'($urandom));
            for (n = 0; n < 300; n++)
            begin
                if (k < 4 && $urandom_range(0, 5) == 0)
                begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
                send_pair(random_pair($urandom_range(0, 4) != 0), n == 299);
            end
            drain();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
